@@ hw/rtl/hsv2rgb_pkg.sv @@
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    localparam int FRAC_BITS = 16;

    localparam int HUE_W = 16;
    localparam int CHAN_W = 8;

    localparam int HUE_FULL = 5760;
    localparam int HUE_SEXTANT = 960;
    localparam int HUE_HALF = HUE_SEXTANT / 2;
    localparam int HUE_BIAS = 6 * HUE_FULL;
    localparam int HUE_BIASED_W = 17;
    localparam int FRAC_W = 10;

    localparam int DIV15_W = 11;
    localparam logic [12:0] DIV15_MUL = 13'd4370;
    localparam int QUOT_W = 7;
    localparam logic [6:0] DIV6_MUL = 7'd43;

    localparam int VQ_W = FRAC_BITS;
    localparam int CQ_W = FRAC_BITS + 1;
    localparam int XP_W = FRAC_BITS + 10;
    localparam int XS_W = XP_W - 6;
    localparam int RECIP_SHIFT = XS_W + 4;
    localparam int RECIP_W = XS_W + 1;
    localparam longint unsigned RECIP_FULL = ((64'd1 << RECIP_SHIFT) + 64'd14) / 64'd15;
    localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_FULL[RECIP_W-1:0];
    localparam int RPROD_W = XS_W + RECIP_W;
    localparam int SCALE_W = CQ_W + 8;

    typedef enum logic [2:0] {
        SEXT_RED_YELLOW,
        SEXT_YELLOW_GREEN,
        SEXT_GREEN_CYAN,
        SEXT_CYAN_BLUE,
        SEXT_BLUE_MAGENTA,
        SEXT_MAGENTA_RED
    } t_sextant;

endpackage

@@ hw/rtl/hsv_to_rgb_converter.sv @@
`timescale 1ns / 1ps

// HSV to RGB color converter.
// The input channel carries one color per transaction: i_hue (signed, 1/16 degree,
// any angle), i_saturation and i_brightness (unsigned Q0.16). The output channel
// carries o_red, o_green and o_blue, each rounded and saturated to 0..255.
// Both channels use valid and stall; a transaction completes at a rising edge
// where valid is high and stall is low.
// The datapath is a six-stage pipeline, and each result leaves from the output
// register of the sixth stage. One color is taken every cycle unless o_stall
// is high; the rate is set by the pipeline, whose widest step is the reciprocal
// multiplier that divides the secondary component by 960.
// When the receiver stalls, the result is held on the output and the stages
// behind it keep filling any empty slots; o_stall rises only once every stage
// holds a color.
// Reset is synchronous and active low; it empties the pipeline and drops o_valid.
module hsv_to_rgb_converter (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic signed [hsv2rgb_pkg::HUE_W-1:0]     i_hue,
    input  logic        [15:0]                       i_saturation,
    input  logic        [15:0]                       i_brightness,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic        [hsv2rgb_pkg::CHAN_W-1:0]    o_red,
    output logic        [hsv2rgb_pkg::CHAN_W-1:0]    o_green,
    output logic        [hsv2rgb_pkg::CHAN_W-1:0]    o_blue
);

    localparam int F = hsv2rgb_pkg::FRAC_BITS;
    localparam int CQ_W = hsv2rgb_pkg::CQ_W;
    localparam int VQ_W = hsv2rgb_pkg::VQ_W;
    localparam int XP_W = hsv2rgb_pkg::XP_W;
    localparam int XS_W = hsv2rgb_pkg::XS_W;
    localparam int RPROD_W = hsv2rgb_pkg::RPROD_W;
    localparam int SCALE_W = hsv2rgb_pkg::SCALE_W;
    localparam int CHAN_W = hsv2rgb_pkg::CHAN_W;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !r_v6 || !i_stall;
    assign en5 = !r_v5 || en6;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    // Stage 1: bias the hue positive and start the division by 960.
    logic [hsv2rgb_pkg::HUE_BIASED_W-1:0] n1_hue_u;
    logic [hsv2rgb_pkg::DIV15_W-1:0]      n1_w;
    logic [23:0]                          n1_wprod;
    logic [31:0]                          n1_sv;

    logic [hsv2rgb_pkg::DIV15_W-1:0] r1_w;
    logic [23:0]                     r1_wprod;
    logic [5:0]                      r1_lo6;
    logic [31:0]                     r1_sv;
    logic [15:0]                     r1_v;

    always_comb begin
        n1_hue_u = hsv2rgb_pkg::HUE_BIASED_W'(hsv2rgb_pkg::HUE_BIAS)
                   + hsv2rgb_pkg::HUE_BIASED_W'(unsigned'(i_hue))
                   - (i_hue[hsv2rgb_pkg::HUE_W-1]
                      ? hsv2rgb_pkg::HUE_BIASED_W'(65536) : '0);
        n1_w     = n1_hue_u[hsv2rgb_pkg::HUE_BIASED_W-1:6];
        n1_wprod = 24'(n1_w) * 24'(hsv2rgb_pkg::DIV15_MUL);
        n1_sv    = 32'(i_saturation) * 32'(i_brightness);
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_w     <= n1_w;
            r1_wprod <= n1_wprod;
            r1_lo6   <= n1_hue_u[5:0];
            r1_sv    <= n1_sv;
            r1_v     <= i_brightness;
        end
    end

    // Stage 2: sextant, fraction, chroma and value level.
    logic [hsv2rgb_pkg::QUOT_W-1:0]  n2_q;
    logic [hsv2rgb_pkg::DIV15_W-1:0] n2_q15;
    logic [3:0]                      n2_rem15;
    logic [11:0]                     n2_q43;
    logic [3:0]                      n2_q6;
    logic [32:0]                     n2_cq_sum;
    logic [16+F-1:0]                 n2_v_wide;

    logic [2:0]                      r2_sext;
    logic [hsv2rgb_pkg::FRAC_W-1:0]  r2_frac;
    logic [CQ_W-1:0]                 r2_cq;
    logic [VQ_W-1:0]                 r2_vq;

    always_comb begin
        n2_q      = r1_wprod[16 +: hsv2rgb_pkg::QUOT_W];
        n2_q15    = hsv2rgb_pkg::DIV15_W'(n2_q) * hsv2rgb_pkg::DIV15_W'(15);
        n2_rem15  = 4'(r1_w - n2_q15);
        n2_q43    = 12'(n2_q) * 12'(hsv2rgb_pkg::DIV6_MUL);
        n2_q6     = n2_q43[11:8];
        n2_cq_sum = 33'(r1_sv) + (33'd1 << (31 - F));
        n2_v_wide = {r1_v, {F{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_sext <= 3'(n2_q - hsv2rgb_pkg::QUOT_W'(n2_q6) * hsv2rgb_pkg::QUOT_W'(6));
            r2_frac <= {n2_rem15, r1_lo6};
            r2_cq   <= n2_cq_sum[32-F +: CQ_W];
            r2_vq   <= n2_v_wide[16 +: VQ_W];
        end
    end

    // Stage 3: secondary component numerator and the offset.
    logic [hsv2rgb_pkg::FRAC_W-1:0] n3_n;
    logic [XP_W-1:0]                n3_xp;
    logic [VQ_W-1:0]                n3_mq;

    logic [XP_W-1:0] r3_xp;
    logic [VQ_W-1:0] r3_mq;
    logic [CQ_W-1:0] r3_cq;
    logic [2:0]      r3_sext;

    always_comb begin
        n3_n  = r2_sext[0]
                ? hsv2rgb_pkg::FRAC_W'(hsv2rgb_pkg::HUE_SEXTANT) - r2_frac
                : r2_frac;
        n3_xp = XP_W'(r2_cq) * XP_W'(n3_n) + XP_W'(hsv2rgb_pkg::HUE_HALF);
        n3_mq = (r2_cq > CQ_W'(r2_vq)) ? '0 : VQ_W'(CQ_W'(r2_vq) - r2_cq);
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_xp   <= n3_xp;
            r3_mq   <= n3_mq;
            r3_cq   <= r2_cq;
            r3_sext <= r2_sext;
        end
    end

    // Stage 4: divide by 960 as a shift by 6 and a reciprocal multiply by 1/15.
    logic [XS_W-1:0]    n4_xs;
    logic [RPROD_W-1:0] r4_prod;
    logic [VQ_W-1:0]    r4_mq;
    logic [CQ_W-1:0]    r4_cq;
    logic [2:0]         r4_sext;

    assign n4_xs = r3_xp[XP_W-1:6];

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_prod <= RPROD_W'(n4_xs) * RPROD_W'(hsv2rgb_pkg::RECIP_MUL);
            r4_mq   <= r3_mq;
            r4_cq   <= r3_cq;
            r4_sext <= r3_sext;
        end
    end

    // Stage 5: place the components by sextant and add the offset.
    logic [CQ_W-1:0] n5_xq;
    logic [CQ_W-1:0] n5_r, n5_g, n5_b;
    logic [CQ_W-1:0] r5_r, r5_g, r5_b;

    always_comb begin
        n5_xq = r4_prod[hsv2rgb_pkg::RECIP_SHIFT +: CQ_W];
        n5_r  = '0;
        n5_g  = '0;
        n5_b  = '0;
        case (hsv2rgb_pkg::t_sextant'(r4_sext))
            hsv2rgb_pkg::SEXT_RED_YELLOW: begin
                n5_r = r4_cq;
                n5_g = n5_xq;
            end
            hsv2rgb_pkg::SEXT_YELLOW_GREEN: begin
                n5_r = n5_xq;
                n5_g = r4_cq;
            end
            hsv2rgb_pkg::SEXT_GREEN_CYAN: begin
                n5_g = r4_cq;
                n5_b = n5_xq;
            end
            hsv2rgb_pkg::SEXT_CYAN_BLUE: begin
                n5_g = n5_xq;
                n5_b = r4_cq;
            end
            hsv2rgb_pkg::SEXT_BLUE_MAGENTA: begin
                n5_r = n5_xq;
                n5_b = r4_cq;
            end
            default: begin
                n5_r = r4_cq;
                n5_b = n5_xq;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_r <= n5_r + CQ_W'(r4_mq);
            r5_g <= n5_g + CQ_W'(r4_mq);
            r5_b <= n5_b + CQ_W'(r4_mq);
        end
    end

    // Stage 6: scale by 255, round half up and saturate.
    function automatic logic [CHAN_W-1:0] to_channel(input logic [CQ_W-1:0] comp);
        logic [SCALE_W-1:0] scaled;
        logic [8:0]         level;
        scaled = (SCALE_W'(comp) << 8) - SCALE_W'(comp) + (SCALE_W'(1) << (F - 1));
        level  = scaled[F +: 9];
        return level[8] ? '1 : level[CHAN_W-1:0];
    endfunction

    logic [CHAN_W-1:0] r6_red, r6_green, r6_blue;

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r6_red   <= to_channel(r5_r);
            r6_green <= to_channel(r5_g);
            r6_blue  <= to_channel(r5_b);
        end
    end

    assign o_valid = r_v6;
    assign o_red   = r6_red;
    assign o_green = r6_green;
    assign o_blue  = r6_blue;

    // The input side is held off only when every stage holds a color.
    a_stall_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && r_v6)
    ) else $error("input stalled while the pipeline has an empty stage");

    // A color that leaves stage 5 lands in the output register.
    a_stage5_advances: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && en6) |=> r_v6
    ) else $error("transaction lost between stage 5 and the output register");

    // The output register holds while the receiver stalls.
    a_output_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v6 && i_stall) |=> (r_v6 && $stable(r6_red) && $stable(r6_green)
                               && $stable(r6_blue))
    ) else $error("stalled result changed");

    // With zero chroma every channel carries the same grey level.
    a_grey_when_no_chroma: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && en5 && r4_cq == '0) |=> (r5_r == r5_g && r5_g == r5_b)
    ) else $error("grey input produced unequal channels");

endmodule
